@@ rtl/ipa_pkg.sv @@
package ipa_pkg;

  localparam int MAX_IDS_DEFAULT = 1024;
  localparam int ID_W            = 32;
  localparam int STATUS_W        = 2;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 32;
  localparam int SIZE_FIELD_W    = 11;
  localparam int POOL_SIZE_RESET = 1024;

  typedef logic [ID_W-1:0]     id_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_EMPTY   = 2'd1;
  localparam status_t ST_ILLEGAL = 2'd2;
  localparam status_t ST_DOUBLE  = 2'd3;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam cfg_idx_t CFG_POOL_SIZE = 2'd0;
  localparam cfg_idx_t CFG_ID_BASE   = 2'd1;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

endpackage

@@ rtl/ipa_if.sv @@
interface ipa_req_if;
  import ipa_pkg::*;
  logic valid;
  logic ready;
  logic op;
  id_t  id;
  modport source (output valid, output op, output id, input ready);
  modport sink   (input valid, input op, input id, output ready);
endinterface

interface ipa_rsp_if;
  import ipa_pkg::*;
  logic    valid;
  logic    ready;
  status_t status;
  id_t     allocated_id;
  modport source (output valid, output status, output allocated_id, input ready);
  modport sink   (input valid, input status, input allocated_id, output ready);
endinterface

interface ipa_cfg_if;
  import ipa_pkg::*;
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/ipa_ram.sv @@
module ipa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data until the next read
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/id_pool_allocator_core.sv @@
// Timing: a request is accepted together with the memory read, then executed and
//   written back into the response register once that register is free.
// A new request is taken only after the previous one has executed, set by the
//   registered read of the free-stack and in-use RAMs that each request waits on.
// Reset (rst, synchronous): pool size min(1024, MAX_IDS), base 0, all IDs free.
//   No clearing pass: watermarks stand in for untouched RAM entries.
module id_pool_allocator_core #(
  parameter int MAX_IDS = ipa_pkg::MAX_IDS_DEFAULT
) (
  input  logic  clk,
  input  logic  rst,
  ipa_req_if.sink   req,
  ipa_rsp_if.source rsp,
  ipa_cfg_if.sink   cfg
);

  import ipa_pkg::*;

  // IW indexes the RAMs; CW holds a count from 0 to MAX_IDS inclusive.
  localparam int IW = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
  localparam int CW = $clog2(MAX_IDS + 1);
  localparam int RESET_SIZE = (POOL_SIZE_RESET > MAX_IDS) ? MAX_IDS : POOL_SIZE_RESET;

  // Free-list bookkeeping.
  //   top     : number of free entries on the stack.
  //   min_top : lowest top reached since the last refill. Stack slots below it
  //             were never written since refill and hold pool_size-1-slot.
  //   pool_size - min_top is the count of indices handed out at least once
  //   since refill; indices at or above it read as not in use.
  state_t         state;
  state_t         state_next;
  logic [CW-1:0]  pool_size;
  id_t            id_base;
  logic [CW-1:0]  top;
  logic [CW-1:0]  top_next;
  logic [CW-1:0]  min_top;
  logic [CW-1:0]  min_top_next;

  // Captured request.
  logic           op_q;
  logic [IW-1:0]  idx_q;
  logic           legal_q;

  // Response register.
  logic           out_valid;
  status_t        out_status;
  id_t            out_id;
  status_t        status_next;
  id_t            alloc_id_next;

  // RAM ports.
  logic           stk_we;
  logic [IW-1:0]  stk_waddr;
  logic [IW-1:0]  stk_wdata;
  logic [IW-1:0]  stk_rdata;
  logic           bm_we;
  logic [IW-1:0]  bm_waddr;
  logic           bm_wdata;
  logic           bm_rdata;

  logic           accept;
  logic           fire;
  logic           cfg_fire;
  id_t            diff_in;
  logic           legal_in;
  logic [CW-1:0]  top_m1;
  logic           virt;
  logic [CW-1:0]  virt_idx;
  logic [IW-1:0]  pop_idx;
  logic [CW-1:0]  hwm;
  logic           in_use;
  logic [SIZE_FIELD_W-1:0] sz_raw;
  logic [CW-1:0]  cfg_size;

  // Take a request only when nothing is in flight; the response register
  // may still hold an earlier result while the next request reads the RAMs.
  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign cfg.ready = 1'b1;
  assign cfg_fire  = cfg.valid && cfg.ready;

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.allocated_id = out_id;

  // Range check on the incoming ID: wraps modulo 2^32, base + size rejected.
  assign diff_in  = req.id - id_base;
  assign legal_in = diff_in < {{(ID_W-CW){1'b0}}, pool_size};
  assign top_m1   = top - CW'(1);

  // Execute once the response register is free to take the result.
  assign fire = (state == S_EXEC) && (!out_valid || rsp.ready);

  // Saturate the written pool size to 1..MAX_IDS.
  assign sz_raw   = cfg.data[SIZE_FIELD_W-1:0];
  assign cfg_size = (sz_raw == '0) ? CW'(1) :
                    ({{(32-SIZE_FIELD_W){1'b0}}, sz_raw} > 32'(MAX_IDS)) ? CW'(MAX_IDS) :
                    CW'(sz_raw);

  ipa_ram #(
    .WIDTH (IW),
    .DEPTH (MAX_IDS),
    .AW    (IW)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .re    (accept),
    .raddr (top_m1[IW-1:0]),
    .rdata (stk_rdata)
  );

  ipa_ram #(
    .WIDTH (1),
    .DEPTH (MAX_IDS),
    .AW    (IW)
  ) u_in_use (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .re    (accept),
    .raddr (diff_in[IW-1:0]),
    .rdata (bm_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (fire) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Pop source: a slot below min_top still holds its refill value.
  assign virt     = top_m1 < min_top;
  assign virt_idx = pool_size - top;
  assign pop_idx  = virt ? virt_idx[IW-1:0] : stk_rdata;
  assign hwm      = pool_size - min_top;
  assign in_use   = (CW'(idx_q) < hwm) && bm_rdata;

  // Execute: decide status, stack and bitmap updates.
  always_comb begin
    stk_we        = 1'b0;
    stk_waddr     = top[IW-1:0];
    stk_wdata     = idx_q;
    bm_we         = 1'b0;
    bm_waddr      = idx_q;
    bm_wdata      = 1'b0;
    top_next      = top;
    min_top_next  = min_top;
    status_next   = ST_OK;
    alloc_id_next = '0;
    if (fire) begin
      if (op_q == OP_ALLOC) begin
        if (top == '0) begin
          status_next = ST_EMPTY;
        end else begin
          bm_we         = 1'b1;
          bm_waddr      = pop_idx;
          bm_wdata      = 1'b1;
          top_next      = top_m1;
          alloc_id_next = id_base + ID_W'(pop_idx);
          if (virt) begin
            min_top_next = top_m1;
          end
        end
      end else begin
        if (!legal_q) begin
          status_next = ST_ILLEGAL;
        end else if (!in_use) begin
          status_next = ST_DOUBLE;
        end else begin
          bm_we = 1'b1;
          // push back unless full; cannot be full with an ID in use
          if (top < CW'(MAX_IDS)) begin
            stk_we   = 1'b1;
            top_next = top + CW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      pool_size <= CW'(RESET_SIZE);
      id_base   <= '0;
      top       <= CW'(RESET_SIZE);
      min_top   <= CW'(RESET_SIZE);
    end else begin
      state <= state_next;
      if (fire) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_fire && (cfg.index == CFG_POOL_SIZE)) begin
        // refill at the new size
        pool_size <= cfg_size;
        top       <= cfg_size;
        min_top   <= cfg_size;
      end else if (cfg_fire && (cfg.index == CFG_ID_BASE)) begin
        id_base <= cfg.data;
        top     <= pool_size;
        min_top <= pool_size;
      end else begin
        top     <= top_next;
        min_top <= min_top_next;
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= req.op;
      idx_q   <= diff_in[IW-1:0];
      legal_q <= legal_in;
    end
    if (fire) begin
      out_status <= status_next;
      out_id     <= alloc_id_next;
    end
  end

endmodule

@@ verif/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ipa_pkg::*;

  localparam int MAX_IDS       = MAX_IDS_DEFAULT;
  localparam int RANDOM_ITEMS  = 1900;
  localparam int SETTLE_CYCLES = 8;    // a little over the request latency
  localparam int LONG_STALL    = 200;  // receiver hold-off used to back up the block
  localparam int MAX_PRINTED   = 50;
  localparam int LIMIT_CYCLES  = 2_000_000;

  // Register indexes the block does not implement; writes to them must be ignored.
  localparam cfg_idx_t CFG_SPARE_2 = 2'd2;
  localparam cfg_idx_t CFG_SPARE_3 = 2'd3;

  typedef struct packed {
    status_t st;
    id_t     aid;
  } alloc_reply_t;

  typedef enum bit {DO_REQ, DO_CFG} row_kind_t;

  // One row of the directed plan: a request or a register write. Where chk is set,
  // the reply is typed in here; otherwise the pool predictor supplies it.
  typedef struct packed {
    row_kind_t kind;
    logic      op;
    cfg_idx_t  idx;
    id_t       val;
    bit        chk;
    status_t   st;
    id_t       aid;
  } plan_row_t;

  localparam int NPLAN = 31;
  localparam plan_row_t PLAN [NPLAN] = '{
    // Default pool: 1024 IDs from 0. Allocation order, LIFO reuse, range edges.
    '{DO_REQ, OP_ALLOC, CFG_POOL_SIZE, 32'h0000_0000, 1'b1, ST_OK,      32'h0000_0000},
    '{DO_REQ, OP_ALLOC, CFG_POOL_SIZE, 32'h0000_0000, 1'b1, ST_OK,      32'h0000_0001},
    '{DO_REQ, OP_FREE,  CFG_POOL_SIZE, 32'h0000_0001, 1'b1, ST_OK,      32'h0000_0000},
    '{DO_REQ, OP_FREE,  CFG_POOL_SIZE, 32'h0000_0001, 1'b1, ST_DOUBLE,  32'h0000_0000},
    '{DO_REQ, OP_ALLOC, CFG_POOL_SIZE, 32'h0000_0000, 1'b1, ST_OK,      32'h0000_0001},
    '{DO_REQ, OP_FREE,  CFG_POOL_SIZE, 32'h0000_0400, 1'b1, ST_ILLEGAL, 32'h0000_0000},
    '{DO_REQ, OP_FREE,  CFG_POOL_SIZE, 32'hFFFF_FFFF, 1'b1, ST_ILLEGAL, 32'h0000_0000},
    '{DO_REQ, OP_FREE,  CFG_POOL_SIZE, 32'h0000_03FF, 1'b1, ST_DOUBLE,  32'h0000_0000},
    // Size 0 is taken as 1: one ID, then empty.
    '{DO_CFG, OP_ALLOC, CFG_POOL_SIZE, 32'h0000_0000, 1'b0, ST_OK,      32'h0000_0000},
    '{DO_REQ, OP_ALLOC, CFG_POOL_SIZE, 32'h0000_0000, 1'b1, ST_OK,      32'h0000_0000},
    '{DO_REQ, OP_ALLOC, CFG_POOL_SIZE, 32'h0000_0000, 1'b1, ST_EMPTY,   32'h0000_0000},
    '{DO_REQ, OP_FREE,  CFG_POOL_SIZE, 32'h0000_0001, 1'b1, ST_ILLEGAL, 32'h0000_0000},
    '{DO_REQ, OP_FREE,  CFG_POOL_SIZE, 32'h0000_0000, 1'b1, ST_OK,      32'h0000_0000},
    '{DO_REQ, OP_ALLOC, CFG_POOL_SIZE, 32'h0000_0000, 1'b0, ST_OK,      32'h0000_0000},
    // Four IDs that wrap past the top of the 32-bit space.
    '{DO_CFG, OP_ALLOC, CFG_ID_BASE,   32'hFFFF_FFFE, 1'b0, ST_OK,      32'h0000_0000},
    '{DO_CFG, OP_ALLOC, CFG_POOL_SIZE, 32'h0000_0004, 1'b0, ST_OK,      32'h0000_0000},
    '{DO_REQ, OP_ALLOC, CFG_POOL_SIZE, 32'h0000_0000, 1'b1, ST_OK,      32'hFFFF_FFFE},
    '{DO_REQ, OP_ALLOC, CFG_POOL_SIZE, 32'h0000_0000, 1'b1, ST_OK,      32'hFFFF_FFFF},
    '{DO_REQ, OP_ALLOC, CFG_POOL_SIZE, 32'h0000_0000, 1'b1, ST_OK,      32'h0000_0000},
    '{DO_REQ, OP_ALLOC, CFG_POOL_SIZE, 32'h0000_0000, 1'b1, ST_OK,      32'h0000_0001},
    '{DO_REQ, OP_ALLOC, CFG_POOL_SIZE, 32'h0000_0000, 1'b1, ST_EMPTY,   32'h0000_0000},
    '{DO_REQ, OP_FREE,  CFG_POOL_SIZE, 32'h0000_0002, 1'b1, ST_ILLEGAL, 32'h0000_0000},
    '{DO_REQ, OP_FREE,  CFG_POOL_SIZE, 32'hFFFF_FFFD, 1'b1, ST_ILLEGAL, 32'h0000_0000},
    // Unimplemented indexes must leave the pool alone: the free below still succeeds.
    '{DO_CFG, OP_ALLOC, CFG_SPARE_2,   32'hFFFF_FFFF, 1'b0, ST_OK,      32'h0000_0000},
    '{DO_CFG, OP_ALLOC, CFG_SPARE_3,   32'h0000_0000, 1'b0, ST_OK,      32'h0000_0000},
    '{DO_REQ, OP_FREE,  CFG_POOL_SIZE, 32'hFFFF_FFFF, 1'b1, ST_OK,      32'h0000_0000},
    '{DO_REQ, OP_ALLOC, CFG_POOL_SIZE, 32'h0000_0000, 1'b0, ST_OK,      32'h0000_0000},
    // Size field 0x7FF saturates to the full pool; base stays near the top.
    '{DO_CFG, OP_ALLOC, CFG_POOL_SIZE, 32'h0000_07FF, 1'b0, ST_OK,      32'h0000_0000},
    '{DO_REQ, OP_FREE,  CFG_POOL_SIZE, 32'hFFFF_FFFE, 1'b1, ST_DOUBLE,  32'h0000_0000},
    '{DO_REQ, OP_FREE,  CFG_POOL_SIZE, 32'h0000_03FE, 1'b1, ST_ILLEGAL, 32'h0000_0000},
    '{DO_REQ, OP_ALLOC, CFG_POOL_SIZE, 32'h0000_0000, 1'b0, ST_OK,      32'h0000_0000}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  ipa_req_if req_ch ();
  ipa_rsp_if rsp_ch ();
  ipa_cfg_if cfg_ch ();

  id_pool_allocator_core uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Pool predictor state: configuration, LIFO of free slots, busy bitmap.
  int unsigned  pool_sz;
  id_t          pool_base;
  bit [9:0]     free_slots [MAX_IDS];
  int unsigned  free_cnt;
  bit           slot_busy [MAX_IDS];
  int unsigned  live_slots [$];   // slots handed out, used to build legal frees
  alloc_reply_t replies_due [$];  // replies owed by the block, oldest first

  int  errors = 0;
  int  replies_seen = 0;
  bit  pace_req = 1'b1;
  bit  pace_rsp = 1'b1;
  bit  long_stall_req = 1'b0;

  task automatic flag_error(input string what);
    if (errors < MAX_PRINTED)
      $display("[%0t] MISMATCH reply %0d: %s", $time, replies_seen, what);
    errors++;
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned idle_cycles();
    if ($urandom_range(0, 15) == 0)
      return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic void pool_refill();
    for (int unsigned i = 0; i < pool_sz; i++)
      free_slots[i[9:0]] = 10'(pool_sz - 1 - i);
    free_cnt = pool_sz;
    foreach (slot_busy[i])
      slot_busy[i] = 1'b0;
    live_slots.delete();
  endfunction

  function automatic void pool_configure(input cfg_idx_t idx, input cfg_data_t val);
    case (idx)
      CFG_POOL_SIZE: begin
        // Only the 11-bit size field counts; clamp it into 1..MAX_IDS.
        pool_sz = 32'(val[SIZE_FIELD_W-1:0]);
        if (pool_sz == 0)
          pool_sz = 1;
        else if (pool_sz > MAX_IDS)
          pool_sz = MAX_IDS;
        pool_refill();
      end
      CFG_ID_BASE: begin
        pool_base = val;
        pool_refill();
      end
      default: ;
    endcase
  endfunction

  // Apply one request to the predicted pool and return the reply it earns.
  function automatic alloc_reply_t pool_apply(input logic op, input id_t id);
    alloc_reply_t r;
    int unsigned  slot;
    id_t          offset;
    int           hit;
    r.st  = ST_OK;
    r.aid = '0;
    hit   = -1;
    if (op == OP_ALLOC) begin
      if (free_cnt == 0) begin
        r.st = ST_EMPTY;
      end else begin
        free_cnt--;
        slot = 32'(free_slots[free_cnt[9:0]]);
        slot_busy[slot[9:0]] = 1'b1;
        r.aid = pool_base + id_t'(slot);
        live_slots.push_back(slot);
      end
    end else begin
      // Offset wraps modulo 2^32, so a range crossing the top continues at 0.
      offset = id - pool_base;
      if (offset >= pool_sz) begin
        r.st = ST_ILLEGAL;
      end else if (!slot_busy[offset[9:0]]) begin
        r.st = ST_DOUBLE;
      end else begin
        slot_busy[offset[9:0]] = 1'b0;
        if (free_cnt < MAX_IDS) begin
          free_slots[free_cnt[9:0]] = offset[9:0];
          free_cnt++;
        end
        for (int k = 0; k < live_slots.size(); k++)
          if (live_slots[k] == offset)
            hit = k;
        if (hit >= 0)
          live_slots.delete(hit);
      end
    end
    return r;
  endfunction

  // Wait until every owed reply is back, then let the pipeline settle.
  task automatic drain_replies();
    while (replies_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Offer one request and hold it until accepted; leave valid high for the caller.
  task automatic send_req(input logic op, input id_t id, input bit typed,
                          input alloc_reply_t typed_reply);
    alloc_reply_t predicted;
    req_ch.valid <= 1'b1;
    req_ch.op    <= op;
    req_ch.id    <= id;
    do @(posedge clk); while (!req_ch.ready);
    predicted = pool_apply(op, id);
    replies_due.push_back(typed ? typed_reply : predicted);
  endtask

  // Register writes go in only once the block is idle.
  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t val);
    drain_replies();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    pool_configure(idx, val);
  endtask

  // Receiver pacing: random stalls, calm stretches, and a long hold-off on request.
  initial begin : rsp_pacer
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (LONG_STALL - 1) @(posedge clk);
      end else if (!pace_rsp || $urandom_range(0, 3) != 0) begin
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= 1'b0;
        repeat (idle_cycles() - 1) @(posedge clk);
      end
    end
  end

  // Check each accepted reply against the oldest one owed.
  always @(posedge clk) begin : reply_check
    alloc_reply_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (replies_due.size() == 0) begin
        flag_error($sformatf("unexpected reply status=%0d id=%h",
                             rsp_ch.status, rsp_ch.allocated_id));
      end else begin
        want = replies_due.pop_front();
        if (rsp_ch.status !== want.st)
          flag_error($sformatf("status %0d, want %0d", rsp_ch.status, want.st));
        if (rsp_ch.allocated_id !== want.aid)
          flag_error($sformatf("allocated_id %h, want %h", rsp_ch.allocated_id, want.aid));
      end
      replies_seen++;
    end
  end

  initial begin : watchdog
    #(LIMIT_CYCLES * 10);
    $display("tb failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned  n_random;
    int unsigned  phase;
    int unsigned  n_phase;
    int unsigned  gap;
    int unsigned  roll;
    int unsigned  burst_left;
    int unsigned  sz_code;
    logic         op;
    id_t          id;
    cfg_data_t    d;
    bit           pause;
    bit           big;
    alloc_reply_t typed_reply;

    n_random   = 0;
    phase      = 0;
    burst_left = 0;

    req_ch.valid <= 1'b0;
    req_ch.op    <= OP_ALLOC;
    req_ch.id    <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_POOL_SIZE;
    cfg_ch.data  <= '0;

    // Mirror the reset state: full default pool at base 0.
    pool_sz   = POOL_SIZE_RESET;
    pool_base = '0;
    pool_refill();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed plan: walk the table, keep valid high between back-to-back requests.
    for (int i = 0; i < NPLAN; i++) begin
      if (PLAN[i].kind == DO_CFG) begin
        write_reg(PLAN[i].idx, PLAN[i].val);
      end else begin
        typed_reply.st  = PLAN[i].st;
        typed_reply.aid = PLAN[i].aid;
        send_req(PLAN[i].op, PLAN[i].val, PLAN[i].chk, typed_reply);
        gap = $urandom_range(0, 2) == 0 ? idle_cycles() : 0;
        if (i == NPLAN - 1 || PLAN[i+1].kind == DO_CFG) begin
          req_ch.valid <= 1'b0;
        end else if (gap != 0) begin
          req_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    // Random phases: new configuration, then a mix weighted toward legal traffic.
    while (n_random < RANDOM_ITEMS) begin
      phase++;

      roll = $urandom_range(0, 99);
      if (roll < 70)      sz_code = $urandom_range(1, 12);
      else if (roll < 85) sz_code = $urandom_range(13, 64);
      else if (roll < 90) sz_code = MAX_IDS;
      else if (roll < 95) sz_code = $urandom_range(MAX_IDS + 1, 2047);
      else                sz_code = 0;
      big = (sz_code == 0) ? 1'b0 : (sz_code > 64);

      // Random upper bits in the size write exercise the whole data bus.
      d = $urandom;
      d[SIZE_FIELD_W-1:0] = sz_code[SIZE_FIELD_W-1:0];
      roll = $urandom_range(0, 3);
      if (roll != 1)
        write_reg(CFG_POOL_SIZE, d);
      if (roll != 0) begin
        case ($urandom_range(0, 3))
          0:       d = '0;
          1:       d = 32'hFFFF_FFFF - $urandom_range(0, 20);
          2:       d = $urandom_range(0, 4096);
          default: d = $urandom;
        endcase
        write_reg(CFG_ID_BASE, d);
      end

      pace_req = $urandom_range(0, 3) != 0;
      pace_rsp = $urandom_range(0, 3) != 0;

      // Every few phases: hold off the receiver and stream requests until the
      // block backs up and drops its ready.
      if (phase % 4 == 1) begin
        long_stall_req = 1'b1;
        burst_left = 60;
      end

      n_phase = big ? 120 : $urandom_range(40, 140);
      for (int k = 0; k < n_phase; k++) begin
        roll = $urandom_range(0, 99);
        op = OP_FREE;
        if (roll < 45 || (roll < 80 && live_slots.size() == 0)) begin
          op = OP_ALLOC;
          id = $urandom;
        end else if (roll < 80) begin
          id = pool_base + id_t'(live_slots[$urandom_range(0, live_slots.size() - 1)]);
        end else if (roll < 88) begin
          id = pool_base + id_t'($urandom_range(0, pool_sz - 1));
        end else if (roll < 95) begin
          id = $urandom;
        end else begin
          id = roll[0] ? pool_base + id_t'(pool_sz) : pool_base - 1;
        end

        send_req(op, id, 1'b0, '0);
        n_random++;

        if (burst_left != 0)
          burst_left--;
        gap   = (pace_req && burst_left == 0 && $urandom_range(0, 2) == 0) ? idle_cycles() : 0;
        pause = burst_left == 0 && $urandom_range(0, 149) == 0;
        if (k == n_phase - 1 || pause) begin
          req_ch.valid <= 1'b0;
          if (pause)
            drain_replies();
        end else if (gap != 0) begin
          req_ch.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    drain_replies();
    if (errors == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule
